// File: hdl/rfga_pkg.sv
// rfga_pkg: shared types, constants and helper functions for the
// radial force gradient accumulator; no dependencies
`timescale 1ns / 1ps

package rfga_pkg;

    localparam int MAX_EXPONENTS_DEF   = 8;
    localparam int MAX_TYPES_DEF       = 8;
    localparam int EXP_TABLE_DEPTH_DEF = 256;

    // configuration port
    localparam int              CFG_IDX_W     = 2;
    localparam int              CFG_DATA_W    = 4;
    localparam logic [1:0]      CFG_NUM_EXP   = 2'd0;
    localparam logic [1:0]      CFG_NUM_TYPES = 2'd1;
    localparam logic [3:0]      NUM_RESET     = 4'd8;

    // result kinds
    localparam logic [1:0] KIND_PART = 2'd0;
    localparam logic [1:0] KIND_EXP  = 2'd1;
    localparam logic [1:0] KIND_TYPE = 2'd2;

    // Q24.24 limits and constants
    localparam logic signed [47:0] MAX48  = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] Q_ONE  = 48'sd16777216;
    localparam logic signed [47:0] Q_TWO  = 48'sd33554432;
    localparam logic signed [49:0] SAT_HI = 50'sd140737488355327;
    localparam logic signed [49:0] SAT_LO = -50'sd140737488355328;

    typedef struct packed {
        logic signed [31:0] grad_self;
        logic signed [31:0] grad_neigh;
        logic signed [31:0] desc_deriv;
        logic signed [31:0] radial_value;
        logic signed [31:0] exponent_value;
        logic        [2:0]  exponent_index;
        logic signed [31:0] net_deriv;
        logic        [2:0]  neighbour_type;
        logic signed [31:0] type_weight;
        logic               last_term;
    } in_t;

    typedef struct packed {
        logic        [1:0]  result_kind;
        logic        [2:0]  result_index;
        logic signed [47:0] result_value;
        logic               last_result;
    } out_t;

    // classified term handed from front to back
    typedef struct packed {
        logic signed [47:0] diff;
        logic signed [47:0] half_deriv;
        logic signed [31:0] radial_value;
        logic signed [31:0] exponent_value;
        logic signed [31:0] net_deriv;
        logic signed [31:0] type_weight;
        logic        [2:0]  exponent_index;
        logic        [2:0]  neighbour_type;
        logic               exp_ok;
        logic               type_ok;
        logic               last_term;
    } work_t;

    function automatic logic signed [49:0] ext50(input logic signed [47:0] v);
        return {{2{v[47]}}, v};
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [47:0] r;
        if (v > SAT_HI) begin
            r = MAX48;
        end else if (v < SAT_LO) begin
            r = ~MAX48;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    // 2^(i/2^lg) in Q.30, truncated taylor sum of exp(i*ln2/2^lg)
    function automatic logic [31:0] exp_entry(input int i, input int lg);
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        z    = (64'd744261118 * 64'(i)) >> lg;
        term = 64'd1 << 30;
        sum  = term;
        for (int n = 1; n <= 20; n++) begin
            term = ((term * z) >> 30) / 64'(n);
            sum  = sum + term;
        end
        if (i == (1 << lg)) begin
            sum = 64'd1 << 31;
        end
        return sum[31:0];
    endfunction

endpackage

// File: hdl/rfga_front.sv
// rfga_front: input acceptance, term classification and a two-entry queue
// depends on rfga_pkg
`timescale 1ns / 1ps

module rfga_front #(
    parameter int MAX_EXPONENTS = rfga_pkg::MAX_EXPONENTS_DEF,
    parameter int MAX_TYPES     = rfga_pkg::MAX_TYPES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rfga_pkg::in_t        s_data,
    output logic                 q_valid,
    input  logic                 q_pop,
    output rfga_pkg::work_t      q_data
);

    rfga_pkg::work_t  fifo_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    rfga_pkg::work_t  cls;
    logic             push;
    logic             pop;
    logic signed [32:0] dd_ext;

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = fifo_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    // halving rounds toward zero
    assign dd_ext = {s_data.desc_deriv[31], s_data.desc_deriv}
                    + {32'd0, s_data.desc_deriv[31]};

    always_comb begin
        cls.diff           = rfga_pkg::sat48(50'(s_data.grad_neigh) - 50'(s_data.grad_self));
        cls.half_deriv     = 48'(dd_ext >>> 1);
        cls.radial_value   = s_data.radial_value;
        cls.exponent_value = s_data.exponent_value;
        cls.net_deriv      = s_data.net_deriv;
        cls.type_weight    = s_data.type_weight;
        cls.exponent_index = s_data.exponent_index;
        cls.neighbour_type = s_data.neighbour_type;
        cls.exp_ok         = (5'(s_data.exponent_index) < 5'(MAX_EXPONENTS));
        cls.type_ok        = (5'(s_data.neighbour_type) < 5'(MAX_TYPES));
        cls.last_term      = s_data.last_term;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: hdl/rfga_qmul.sv
// rfga_qmul: shared Q24.24 multiplier, four 24x24 partial products followed
// by a saturation step; depends on rfga_pkg
`timescale 1ns / 1ps

module rfga_qmul (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [47:0] a,
    input  logic signed [47:0] b,
    output logic               done,
    output logic signed [47:0] y
);

    logic               busy_reg;
    logic [2:0]         ph_reg;
    logic               neg_reg;
    logic [23:0]        ah_reg, al_reg, bh_reg, bl_reg;
    logic               hsat_reg;
    logic [49:0]        acc_reg;
    logic               done_reg;
    logic signed [47:0] y_reg;
    logic [47:0]        ma, mb;
    logic [23:0]        op_x, op_y;
    logic [47:0]        pp;
    logic [48:0]        mm;
    logic signed [49:0] sv;

    assign ma   = a[47] ? 48'(-a) : 48'(a);
    assign mb   = b[47] ? 48'(-b) : 48'(b);
    assign done = done_reg;
    assign y    = y_reg;

    always_comb begin
        case (ph_reg)
            3'd0:    begin op_x = ah_reg; op_y = bh_reg; end
            3'd1:    begin op_x = ah_reg; op_y = bl_reg; end
            3'd2:    begin op_x = al_reg; op_y = bh_reg; end
            default: begin op_x = al_reg; op_y = bl_reg; end
        endcase
        pp = 48'(op_x) * 48'(op_y);
        mm = (hsat_reg || acc_reg > 50'h1_0000_0000_0000) ? 49'h1_0000_0000_0000
                                                            : acc_reg[48:0];
        sv = neg_reg ? -$signed({1'b0, mm}) : $signed({1'b0, mm});
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg  <= a[47] ^ b[47];
            ah_reg   <= ma[47:24];
            al_reg   <= ma[23:0];
            bh_reg   <= mb[47:24];
            bl_reg   <= mb[23:0];
            acc_reg  <= 50'd0;
            hsat_reg <= 1'b0;
        end else if (busy_reg) begin
            case (ph_reg)
                3'd0: begin
                    hsat_reg <= (pp[47:24] != 24'd0);
                    acc_reg  <= {2'd0, pp[23:0], 24'd0};
                end
                3'd1, 3'd2: acc_reg <= acc_reg + 50'(pp);
                3'd3:       acc_reg <= acc_reg + 50'(pp[47:24]);
                default:    y_reg   <= rfga_pkg::sat48(sv);
            endcase
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ph_reg   <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && !start && (ph_reg == 3'd4);
            if (start) begin
                busy_reg <= 1'b1;
                ph_reg   <= 3'd0;
            end else if (busy_reg) begin
                ph_reg <= ph_reg + 3'd1;
                if (ph_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// File: hdl/rfga_exp.sv
// rfga_exp: pipelined exp of a Q24.24 value through a 2^f table with linear
// interpolation; depends on rfga_pkg
`timescale 1ns / 1ps

module rfga_exp #(
    parameter int EXP_TABLE_DEPTH = rfga_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [47:0] x,
    output logic               done,
    output logic signed [47:0] y
);

    localparam int L = $clog2(EXP_TABLE_DEPTH);
    localparam logic signed [47:0] X_LO = -48'sd805306368;  // -48.0
    localparam logic signed [47:0] X_HI = 48'sd268435456;   // 16.0
    localparam logic signed [31:0] LOG2E = 32'sd1549082005;

    logic [31:0]        tab_w [EXP_TABLE_DEPTH + 1];
    logic [4:0]         vld_reg;
    logic [3:0]         zero_reg;
    logic signed [31:0] xc_reg;
    logic signed [63:0] prod_reg;
    logic signed [9:0]  k3_reg, k4_reg;
    logic [31:0]        lo_reg, dlt_reg, m_reg;
    logic [23:0]        rem_reg;
    logic signed [47:0] y_reg;
    logic signed [33:0] yq;
    logic [23:0]        f;
    logic [L-1:0]       idx;
    logic [L:0]         idx_lo, idx_hi;
    logic [55:0]        ip;
    logic signed [10:0] sh;
    logic [10:0]        nsh;
    logic [48:0]        up;
    logic signed [47:0] res;

    for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_tab
        assign tab_w[gi] = rfga_pkg::exp_entry(gi, L);
    end

    assign done = vld_reg[4];
    assign y    = y_reg;

    always_comb begin
        yq     = 34'(prod_reg >>> 30);
        f      = yq[23:0];
        idx    = f[23 -: L];
        idx_lo = {1'b0, idx};
        idx_hi = idx_lo + (L+1)'(1);
        ip     = 56'(dlt_reg) * 56'(rem_reg);
        sh     = 11'(k4_reg) - 11'sd6;
        nsh    = 11'(-sh);
        up     = 49'(m_reg) << sh[4:0];
        if (zero_reg[3]) begin
            res = 48'sd0;
        end else if (sh >= 11'sd17) begin
            res = rfga_pkg::MAX48;
        end else if (sh >= 11'sd0) begin
            res = (up > 49'(rfga_pkg::MAX48)) ? rfga_pkg::MAX48 : $signed(up[47:0]);
        end else if (nsh >= 11'd32) begin
            res = 48'sd0;
        end else begin
            res = $signed(48'(m_reg >> nsh[4:0]));
        end
    end

    always_ff @(posedge aclk) begin
        xc_reg   <= 32'((x > X_HI) ? X_HI : x);
        zero_reg <= {zero_reg[2:0], (x < X_LO)};
        prod_reg <= 64'(xc_reg) * 64'(LOG2E);
        k3_reg   <= yq[33:24];
        lo_reg   <= tab_w[idx_lo];
        dlt_reg  <= tab_w[idx_hi] - tab_w[idx_lo];
        rem_reg  <= {f[23-L:0], L'(0)};
        k4_reg   <= k3_reg;
        m_reg    <= lo_reg + 32'(ip >> 24);
        y_reg    <= res;
        if (!aresetn) begin
            vld_reg <= 5'd0;
        end else begin
            vld_reg <= {vld_reg[3:0], start};
        end
    end

endmodule

// File: hdl/rfga_back.sv
// rfga_back: sequencer over the shared multiplier and exp unit, totals,
// configuration registers and the result register; depends on rfga_pkg,
// rfga_qmul and rfga_exp
`timescale 1ns / 1ps

module rfga_back #(
    parameter int MAX_EXPONENTS   = rfga_pkg::MAX_EXPONENTS_DEF,
    parameter int MAX_TYPES       = rfga_pkg::MAX_TYPES_DEF,
    parameter int EXP_TABLE_DEPTH = rfga_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  rfga_pkg::work_t                   q_data,
    input  logic                              cfg_valid,
    input  logic [rfga_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rfga_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rfga_pkg::out_t                    m_data
);

    localparam int EIW  = (MAX_EXPONENTS > 1) ? $clog2(MAX_EXPONENTS) : 1;
    localparam int TIW  = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
    localparam int MAXN = (MAX_EXPONENTS > MAX_TYPES) ? MAX_EXPONENTS : MAX_TYPES;
    localparam int CW   = $clog2(MAXN + 1);

    // multiplier steps, in issue order
    localparam logic [3:0] S_AD = 4'd0, S_S = 4'd1, S_P = 4'd2, S_PW = 4'd3,
                           S_CONTRIB = 4'd4, S_PG = 4'd5, S_WE = 4'd6,
                           S_DQ = 4'd7, S_BUF = 4'd8, S_EV = 4'd9, S_TV = 4'd10;
    localparam int NSTEP = 11;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_EXP, ST_ACC, ST_EMIT0, ST_EMIT_E, ST_EMIT_T
    } state_t;

    state_t             state_reg;
    rfga_pkg::work_t    work_reg;
    logic [3:0]         step_reg;
    logic               issued_reg;
    logic signed [47:0] res_reg [NSTEP];
    logic signed [47:0] e_reg, q1_reg, q2_reg;
    logic [CW-1:0]      cnt_reg;
    logic signed [47:0] etot_reg [MAX_EXPONENTS];
    logic signed [47:0] ttot_reg [MAX_TYPES];
    logic [3:0]         num_exp_reg, num_types_reg;
    logic               m_valid_reg;
    rfga_pkg::out_t     m_data_reg;

    logic               mul_start, mul_done, exp_start, exp_done;
    logic signed [47:0] mul_a, mul_b, mul_y, exp_y;
    logic [4:0]         ne, nt;
    logic               out_free;
    logic               emit_go;
    logic [EIW-1:0]     e_addr;
    logic [TIW-1:0]     t_addr;
    logic signed [47:0] e_rd, t_rd;
    logic [4:0]         cnt_inc;

    assign ne = ({1'b0, num_exp_reg} > 5'(MAX_EXPONENTS)) ? 5'(MAX_EXPONENTS)
                                                          : {1'b0, num_exp_reg};
    assign nt = ({1'b0, num_types_reg} > 5'(MAX_TYPES)) ? 5'(MAX_TYPES)
                                                        : {1'b0, num_types_reg};
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_go   = out_free && (state_reg inside {ST_EMIT0, ST_EMIT_E, ST_EMIT_T});
    assign mul_start = (state_reg == ST_MUL) && !issued_reg;
    assign exp_start = (state_reg == ST_EXP) && !issued_reg;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cnt_inc   = 5'(cnt_reg) + 5'd1;

    assign e_addr = (state_reg == ST_ACC) ? EIW'(work_reg.exponent_index) : cnt_reg[EIW-1:0];
    assign t_addr = (state_reg == ST_ACC) ? TIW'(work_reg.neighbour_type) : cnt_reg[TIW-1:0];
    assign e_rd   = etot_reg[e_addr];
    assign t_rd   = ttot_reg[t_addr];

    always_comb begin
        case (step_reg)
            S_AD:      begin mul_a = 48'(work_reg.exponent_value); mul_b = 48'(work_reg.radial_value); end
            S_S:       begin mul_a = e_reg;              mul_b = q1_reg; end
            S_P:       begin mul_a = work_reg.diff;      mul_b = work_reg.half_deriv; end
            S_PW:      begin mul_a = res_reg[S_P];       mul_b = 48'(work_reg.type_weight); end
            S_CONTRIB: begin mul_a = res_reg[S_PW];      mul_b = res_reg[S_S]; end
            S_PG:      begin mul_a = res_reg[S_P];       mul_b = 48'(work_reg.net_deriv); end
            S_WE:      begin mul_a = 48'(work_reg.type_weight); mul_b = e_reg; end
            S_DQ:      begin mul_a = 48'(work_reg.radial_value); mul_b = q2_reg; end
            S_BUF:     begin mul_a = res_reg[S_WE];      mul_b = res_reg[S_DQ]; end
            S_EV:      begin mul_a = res_reg[S_PG];      mul_b = res_reg[S_BUF]; end
            default:   begin mul_a = res_reg[S_PG];      mul_b = res_reg[S_S]; end
        endcase
    end

    rfga_qmul u_qmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .y       (mul_y)
    );

    rfga_exp #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_exp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (exp_start),
        .x       (res_reg[S_AD]),
        .done    (exp_done),
        .y       (exp_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            num_exp_reg   <= rfga_pkg::NUM_RESET;
            num_types_reg <= rfga_pkg::NUM_RESET;
            step_reg      <= S_AD;
            cnt_reg       <= '0;
            for (int i = 0; i < MAX_EXPONENTS; i++) etot_reg[i] <= 48'sd0;
            for (int i = 0; i < MAX_TYPES; i++)     ttot_reg[i] <= 48'sd0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    rfga_pkg::CFG_NUM_EXP:   num_exp_reg   <= cfg_data;
                    rfga_pkg::CFG_NUM_TYPES: num_types_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (emit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        work_reg  <= q_data;
                        step_reg  <= S_AD;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (!issued_reg) begin
                        issued_reg <= 1'b1;
                    end else if (mul_done) begin
                        issued_reg         <= 1'b0;
                        res_reg[step_reg]  <= mul_y;
                        if (step_reg == S_AD) begin
                            q1_reg    <= rfga_pkg::sat48(rfga_pkg::ext50(rfga_pkg::Q_ONE)
                                                         + rfga_pkg::ext50(mul_y));
                            q2_reg    <= rfga_pkg::sat48(rfga_pkg::ext50(rfga_pkg::Q_TWO)
                                                         + rfga_pkg::ext50(mul_y));
                            state_reg <= ST_EXP;
                        end else if (step_reg == S_TV) begin
                            state_reg <= ST_ACC;
                        end else begin
                            step_reg <= step_reg + 4'd1;
                        end
                    end
                end
                ST_EXP: begin
                    if (!issued_reg) begin
                        issued_reg <= 1'b1;
                    end else if (exp_done) begin
                        issued_reg <= 1'b0;
                        e_reg      <= exp_y;
                        step_reg   <= S_S;
                        state_reg  <= ST_MUL;
                    end
                end
                ST_ACC: begin
                    if (work_reg.exp_ok) begin
                        etot_reg[e_addr] <= rfga_pkg::sat48(rfga_pkg::ext50(e_rd)
                                                            + rfga_pkg::ext50(res_reg[S_EV]));
                    end
                    if (work_reg.type_ok) begin
                        ttot_reg[t_addr] <= rfga_pkg::sat48(rfga_pkg::ext50(t_rd)
                                                            + rfga_pkg::ext50(res_reg[S_TV]));
                    end
                    state_reg <= ST_EMIT0;
                end
                ST_EMIT0: begin
                    if (out_free) begin
                        m_data_reg.result_kind    <= rfga_pkg::KIND_PART;
                        m_data_reg.result_index   <= work_reg.exponent_index;
                        m_data_reg.result_value   <= res_reg[S_CONTRIB];
                        m_data_reg.last_result    <= !work_reg.last_term
                                                     || (ne == 5'd0 && nt == 5'd0);
                        cnt_reg                   <= '0;
                        if (!work_reg.last_term) begin
                            state_reg <= ST_IDLE;
                        end else if (ne != 5'd0) begin
                            state_reg <= ST_EMIT_E;
                        end else if (nt != 5'd0) begin
                            state_reg <= ST_EMIT_T;
                        end else begin
                            for (int i = 0; i < MAX_EXPONENTS; i++) etot_reg[i] <= 48'sd0;
                            for (int i = 0; i < MAX_TYPES; i++)     ttot_reg[i] <= 48'sd0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_EMIT_E: begin
                    if (out_free) begin
                        m_data_reg.result_kind    <= rfga_pkg::KIND_EXP;
                        m_data_reg.result_index   <= 3'(cnt_reg);
                        m_data_reg.result_value   <= e_rd;
                        m_data_reg.last_result    <= (cnt_inc == ne) && (nt == 5'd0);
                        if (cnt_inc == ne) begin
                            cnt_reg <= '0;
                            if (nt != 5'd0) begin
                                state_reg <= ST_EMIT_T;
                            end else begin
                                for (int i = 0; i < MAX_EXPONENTS; i++) etot_reg[i] <= 48'sd0;
                                for (int i = 0; i < MAX_TYPES; i++)     ttot_reg[i] <= 48'sd0;
                                state_reg <= ST_IDLE;
                            end
                        end else begin
                            cnt_reg <= cnt_reg + CW'(1);
                        end
                    end
                end
                ST_EMIT_T: begin
                    if (out_free) begin
                        m_data_reg.result_kind    <= rfga_pkg::KIND_TYPE;
                        m_data_reg.result_index   <= 3'(cnt_reg);
                        m_data_reg.result_value   <= t_rd;
                        m_data_reg.last_result    <= (cnt_inc == nt);
                        if (cnt_inc == nt) begin
                            cnt_reg <= '0;
                            for (int i = 0; i < MAX_EXPONENTS; i++) etot_reg[i] <= 48'sd0;
                            for (int i = 0; i < MAX_TYPES; i++)     ttot_reg[i] <= 48'sd0;
                            state_reg <= ST_IDLE;
                        end else begin
                            cnt_reg <= cnt_reg + CW'(1);
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/radial_force_gradient_accumulator_unit.sv
// Radial force gradient accumulator, top level.
// Terms arrive on s_valid/s_ready/s_data, one (particle, neighbour, direction,
// exponent) term per transfer. Each term yields one particle gradient result
// on m_valid/m_ready/m_data; a term with last_term set is followed by the
// exponent totals and then the type totals, after which all totals are zeroed.
// last_result marks the final result caused by a term.
// Registers num_exponents (index 0) and num_types (index 1) are written over
// cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Write them only while
// the block is idle.
// Eleven Q24.24 products share one multiplier of four 24x24 partial products
// plus a saturation step, with the exp lookup pipeline after the first
// product; queue pop, accumulate and result load are each registered steps.
// A last term then emits one total per cycle while the receiver accepts.
// The back end works on one term at a time, paced by the shared multiplier;
// a two-entry queue takes new terms while the back end works; a stalled
// receiver holds the result register and pauses the sequencer.
// Reset (synchronous, aresetn low) zeroes the totals, empties the queue and
// sets both counts to 8.
// Depends on rfga_pkg, rfga_front and rfga_back.
`timescale 1ns / 1ps

module radial_force_gradient_accumulator_unit #(
    parameter int MAX_EXPONENTS   = rfga_pkg::MAX_EXPONENTS_DEF,
    parameter int MAX_TYPES       = rfga_pkg::MAX_TYPES_DEF,
    parameter int EXP_TABLE_DEPTH = rfga_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rfga_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rfga_pkg::out_t                    m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rfga_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rfga_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic            q_valid;
    logic            q_pop;
    rfga_pkg::work_t q_data;

    assign cfg_ready = 1'b1;

    rfga_front #(
        .MAX_EXPONENTS (MAX_EXPONENTS),
        .MAX_TYPES     (MAX_TYPES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data)
    );

    rfga_back #(
        .MAX_EXPONENTS   (MAX_EXPONENTS),
        .MAX_TYPES       (MAX_TYPES),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: dv/tb.sv
// tb: self-checking testbench for radial_force_gradient_accumulator_unit
// holds its own fixed-point predictor of the gradient terms and totals
// depends on rfga_pkg and the rtl of the unit
`timescale 1ns / 1ps

class force_grad_scoreboard;
    localparam longint QONE  = 64'sd16777216;
    localparam longint HI48  = 64'sd140737488355327;
    localparam longint LO48  = -64'sd140737488355328;
    localparam longint LOG2E = 64'sd1549082005;
    localparam longint LN2   = 64'sd744261118;

    bit [63:0]      exp_lut[0:256];
    longint         exp_sum[8];
    longint         type_sum[8];
    bit [3:0]       num_exp;
    bit [3:0]       num_types;
    rfga_pkg::out_t pending[$];
    int             errors;

    function new();
        bit [63:0] z;
        bit [63:0] term;
        bit [63:0] acc;
        for (int i = 0; i <= 256; i++) begin
            z    = (64'(LN2) * 64'(i)) / 64'd256;
            term = 64'd1 << 30;
            acc  = term;
            for (int n = 1; n <= 20; n++) begin
                term = ((term * z) >> 30) / 64'(n);
                acc  = acc + term;
            end
            exp_lut[i] = acc;
        end
        exp_lut[256] = 64'd1 << 31;
        num_exp   = 4'd8;
        num_types = 4'd8;
        errors    = 0;
        foreach (exp_sum[i]) exp_sum[i] = 0;
        foreach (type_sum[i]) type_sum[i] = 0;
    endfunction

    function longint clip48(longint v);
        if (v > HI48) return HI48;
        if (v < LO48) return LO48;
        return v;
    endfunction

    // Q24.24 product, truncated toward zero
    function longint mul_q(longint a, longint b);
        bit        neg;
        bit [63:0] ma, mb, ah, al, bh, bl, hh, m;
        neg = (a < 0) != (b < 0);
        ma  = a < 0 ? 64'(-a) : 64'(a);
        mb  = b < 0 ? 64'(-b) : 64'(b);
        ah  = ma >> 24;
        al  = ma & 64'hFFFFFF;
        bh  = mb >> 24;
        bl  = mb & 64'hFFFFFF;
        hh  = ah * bh;
        if (hh >= (64'd1 << 24)) m = 64'd1 << 48;
        else m = (hh << 24) + ah * bl + al * bh + ((al * bl) >> 24);
        if (m > (64'd1 << 48)) m = 64'd1 << 48;
        return clip48(neg ? -longint'(m) : longint'(m));
    endfunction

    function longint exp_q(longint x);
        longint    y, k, sh;
        bit [63:0] f, pos, idx, rem, m;
        if (x < -48 * QONE) return 0;
        if (x > 16 * QONE) x = 16 * QONE;
        y   = (x * LOG2E) >>> 30;
        k   = y >>> 24;
        f   = 64'(y - k * QONE);
        pos = f * 64'd256;
        idx = pos >> 24;
        rem = pos & 64'hFFFFFF;
        m   = exp_lut[idx] + (((exp_lut[idx + 1] - exp_lut[idx]) * rem) >> 24);
        sh  = k - 6;
        if (sh >= 0) begin
            if (sh >= 17) return HI48;
            return clip48(longint'(m << sh));
        end
        if (-sh >= 63) return 0;
        return longint'(m >> (-sh));
    endfunction

    function void set_count(logic [1:0] idx, logic [3:0] val);
        if (idx == rfga_pkg::CFG_NUM_EXP) num_exp = val;
        else if (idx == rfga_pkg::CFG_NUM_TYPES) num_types = val;
    endfunction

    function void push_result(logic [1:0] kind, int idx, longint v, bit lst);
        rfga_pkg::out_t r;
        r.result_kind  = kind;
        r.result_index = idx[2:0];
        r.result_value = v[47:0];
        r.last_result  = lst;
        pending.push_back(r);
    endfunction

    function void note_term(rfga_pkg::in_t t);
        longint diff, c, ad, e, s, p, pg, w, d, g, buf_v;
        int     ne, nt;
        d     = longint'(t.radial_value);
        w     = longint'(t.type_weight);
        g     = longint'(t.net_deriv);
        diff  = clip48(longint'(t.grad_neigh) - longint'(t.grad_self));
        c     = mul_q(longint'(t.desc_deriv), QONE / 2);
        ad    = mul_q(longint'(t.exponent_value), d);
        e     = exp_q(ad);
        s     = mul_q(e, clip48(QONE + ad));
        p     = mul_q(diff, c);
        pg    = mul_q(p, g);
        buf_v = mul_q(mul_q(w, e), mul_q(d, clip48(2 * QONE + ad)));
        exp_sum[t.exponent_index]  = clip48(exp_sum[t.exponent_index] + mul_q(pg, buf_v));
        type_sum[t.neighbour_type] = clip48(type_sum[t.neighbour_type] + mul_q(pg, s));
        ne = num_exp > 8 ? 8 : num_exp;
        nt = num_types > 8 ? 8 : num_types;
        push_result(rfga_pkg::KIND_PART, t.exponent_index, mul_q(mul_q(p, w), s),
                    !t.last_term || (ne == 0 && nt == 0));
        if (t.last_term) begin
            for (int i = 0; i < ne; i++)
                push_result(rfga_pkg::KIND_EXP, i, exp_sum[i], i + 1 == ne && nt == 0);
            for (int i = 0; i < nt; i++)
                push_result(rfga_pkg::KIND_TYPE, i, type_sum[i], i + 1 == nt);
            foreach (exp_sum[i]) exp_sum[i] = 0;
            foreach (type_sum[i]) type_sum[i] = 0;
        end
    endfunction

    function void check_result(rfga_pkg::out_t got);
        rfga_pkg::out_t want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
        end
        want = pending.pop_front();
        if (got.result_kind !== want.result_kind || got.result_index !== want.result_index
            || got.result_value !== want.result_value
            || got.last_result !== want.last_result) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
    endfunction
endclass

module tb;
    localparam logic [1:0] CFG_SPARE = 2'd2;
    localparam int         STALL_LIMIT = 20000;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    rfga_pkg::in_t  s_data = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    rfga_pkg::out_t m_data;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [1:0]     cfg_index = '0;
    logic [3:0]     cfg_data = '0;

    force_grad_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req = 0;
    int hold_cnt = 0;
    int quiet_cycles = 0;

    always #4 aclk = ~aclk;

    radial_force_gradient_accumulator_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // receiver: random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // monitors and watchdog
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_term(s_data);
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL radial_force_gradient_accumulator_unit");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_count(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_term(rfga_pkg::in_t t);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // mostly modest reals so the exp path stays in range, sometimes full width
    function automatic logic [31:0] rand_real();
        if ($urandom_range(3) == 0) return $urandom;
        return 32'($signed($urandom_range(67108863)) - 33554432);
    endfunction

    function automatic rfga_pkg::in_t rand_term();
        rfga_pkg::in_t t;
        t.grad_self      = rand_real();
        t.grad_neigh     = rand_real();
        t.desc_deriv     = rand_real();
        t.radial_value   = rand_real();
        t.exponent_value = rand_real();
        t.exponent_index = 3'($urandom_range(7));
        t.net_deriv      = rand_real();
        t.neighbour_type = 3'($urandom_range(7));
        t.type_weight    = rand_real();
        t.last_term      = ($urandom_range(7) == 0);
        return t;
    endfunction

    task automatic directed_terms();
        rfga_pkg::in_t t;
        t = '0;
        send_term(t);
        t = '1;
        send_term(t);
        t = {7{32'h7FFF_FFFF}} | '0;
        t.grad_self = 32'h8000_0000; t.grad_neigh = 32'h7FFF_FFFF;
        t.desc_deriv = 32'h7FFF_FFFF; t.radial_value = 32'h7FFF_FFFF;
        t.exponent_value = 32'h7FFF_FFFF; t.net_deriv = 32'h7FFF_FFFF;
        t.type_weight = 32'h7FFF_FFFF; t.exponent_index = 3'd7;
        t.neighbour_type = 3'd7; t.last_term = 1'b0;
        send_term(t);
        t.exponent_value = 32'h8000_0000;
        t.type_weight = 32'h8000_0000; t.last_term = 1'b1;
        send_term(t);
        // exp argument far below the cutoff, near it, and above the clamp
        for (int i = 0; i < 8; i++) begin
            t = rand_term();
            t.exponent_index = 3'(i);
            t.neighbour_type = 3'(7 - i);
            t.exponent_value = 32'(-8) <<< 24;
            t.radial_value   = (i < 3) ? 32'd7 << 24 : (i < 5) ? 32'd6 << 24 : -(32'd5 << 24);
            t.last_term      = (i == 7);
            send_term(t);
        end
        t = rand_term();
        t.exponent_value = 32'd4 << 24;
        t.radial_value   = 32'd4 << 24;
        t.last_term      = 1'b1;
        send_term(t);
    endtask

    task automatic random_terms(int n, bit pause_mid);
        for (int i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2) drain_results();
            send_term(rand_term());
        end
        t_last: begin
            rfga_pkg::in_t t;
            t = rand_term();
            t.last_term = 1'b1;
            send_term(t);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 6;
        rx_idle_pct = 79;
        directed_terms();
        random_terms(40, 1'b0);
        drain_results();
        write_reg(rfga_pkg::CFG_NUM_EXP, 4'd1);
        write_reg(rfga_pkg::CFG_NUM_TYPES, 4'd1);
        random_terms(60, 1'b0);
        drain_results();

        tx_idle_pct = 79;
        rx_idle_pct = 6;
        write_reg(rfga_pkg::CFG_NUM_EXP, 4'd0);
        write_reg(rfga_pkg::CFG_NUM_TYPES, 4'd0);
        random_terms(60, 1'b0);
        drain_results();
        write_reg(rfga_pkg::CFG_NUM_EXP, 4'd15);
        write_reg(rfga_pkg::CFG_NUM_TYPES, 4'd3);
        write_reg(CFG_SPARE, 4'd5);
        random_terms(60, 1'b0);
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(rfga_pkg::CFG_NUM_EXP, 4'd0);
        write_reg(rfga_pkg::CFG_NUM_TYPES, 4'd8);
        // long receiver hold-off so the input queue fills and back-pressures
        hold_req = 3000;
        random_terms(60, 1'b0);
        drain_results();
        write_reg(rfga_pkg::CFG_NUM_EXP, 4'd8);
        write_reg(rfga_pkg::CFG_NUM_TYPES, 4'd9);
        random_terms(60, 1'b1);
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS radial_force_gradient_accumulator_unit");
        else
            $display("FAIL radial_force_gradient_accumulator_unit");
        $finish;
    end
endmodule
